// ===== src/u8esc_pkg.sv =====
// Types, constants, microcode and helper functions of the UTF-8 checking C string escaper.
package u8esc_pkg;

    localparam int PC_W = 4;

    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] LEAD2_LO  = 8'hC0;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD_MAX  = 8'hF4;
    localparam logic [7:0] SURR_LO   = 8'hA0;
    localparam logic [7:0] PLANE_LO  = 8'h90;
    localparam logic [7:0] OVER2_MAX = 8'hC1;
    localparam logic [7:0] SURR_LEAD = 8'hED;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [PC_W-1:0] PC_OPEN     = 4'd0;
    localparam logic [PC_W-1:0] PC_DISPATCH = 4'd1;
    localparam logic [PC_W-1:0] PC_HEX      = 4'd2;
    localparam logic [PC_W-1:0] PC_HEX_X    = 4'd3;
    localparam logic [PC_W-1:0] PC_HEX_HI   = 4'd4;
    localparam logic [PC_W-1:0] PC_HEX_LO   = 4'd5;
    localparam logic [PC_W-1:0] PC_CLOSE    = 4'd6;
    localparam logic [PC_W-1:0] PC_SINGLE   = 4'd7;
    localparam logic [PC_W-1:0] PC_LETTER   = 4'd8;
    localparam logic [PC_W-1:0] PC_BRK_Q1   = 4'd9;
    localparam logic [PC_W-1:0] PC_BRK_SP   = 4'd10;
    localparam logic [PC_W-1:0] PC_BRK_Q2   = 4'd11;
    localparam logic [PC_W-1:0] PC_RAW      = 4'd12;

    typedef enum logic [3:0] {
        E_NONE, E_QUOTE, E_BSL, E_X, E_HI, E_LO, E_RAW, E_LETTER, E_SPACE
    } t_emit;

    typedef enum logic [3:0] {
        C_NEVER, C_ALWAYS, C_OPEN, C_SINGLE, C_NO_HEX, C_CLOSE,
        C_HI, C_ESC, C_NO_ESC, C_BRK, C_MORE
    } t_cond;

    typedef enum logic [1:0] {
        L_NO, L_YES, L_OPEN, L_BYTE
    } t_lastsel;

    typedef struct packed {
        t_emit           emit;
        t_cond           emit_cond;
        t_lastsel        last;
        t_cond           jump_cond;
        logic [PC_W-1:0] target;
        logic            inc_idx;
        logic            done;
    } t_uop;

    typedef struct packed {
        logic need_open;
        logic single;
        logic no_hex;
        logic close;
        logic hi;
        logic esc;
        logic brk;
        logic more;
    } t_flags;

    function automatic t_uop mk(input t_emit e, input t_cond ec, input t_lastsel l,
                                input t_cond jc, input logic [PC_W-1:0] t,
                                input logic inc, input logic d);
        t_uop u;
        u.emit      = e;
        u.emit_cond = ec;
        u.last      = l;
        u.jump_cond = jc;
        u.target    = t;
        u.inc_idx   = inc;
        u.done      = d;
        return u;
    endfunction

    function automatic t_uop ucode(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            PC_OPEN:     u = mk(E_QUOTE,  C_OPEN,   L_OPEN, C_SINGLE, PC_SINGLE, 1'b0, 1'b0);
            PC_DISPATCH: u = mk(E_NONE,   C_NEVER,  L_NO,   C_NO_HEX, PC_CLOSE,  1'b0, 1'b0);
            PC_HEX:      u = mk(E_BSL,    C_ALWAYS, L_NO,   C_NEVER,  PC_OPEN,   1'b0, 1'b0);
            PC_HEX_X:    u = mk(E_X,      C_ALWAYS, L_NO,   C_NEVER,  PC_OPEN,   1'b0, 1'b0);
            PC_HEX_HI:   u = mk(E_HI,     C_HI,     L_NO,   C_NEVER,  PC_OPEN,   1'b0, 1'b0);
            PC_HEX_LO:   u = mk(E_LO,     C_ALWAYS, L_BYTE, C_MORE,   PC_HEX,    1'b1, 1'b0);
            PC_CLOSE:    u = mk(E_QUOTE,  C_CLOSE,  L_YES,  C_NEVER,  PC_OPEN,   1'b0, 1'b1);
            PC_SINGLE:   u = mk(E_BSL,    C_ESC,    L_NO,   C_NO_ESC, PC_BRK_Q1, 1'b0, 1'b0);
            PC_LETTER:   u = mk(E_LETTER, C_ALWAYS, L_YES,  C_NEVER,  PC_OPEN,   1'b0, 1'b1);
            PC_BRK_Q1:   u = mk(E_QUOTE,  C_BRK,    L_NO,   C_NEVER,  PC_OPEN,   1'b0, 1'b0);
            PC_BRK_SP:   u = mk(E_SPACE,  C_BRK,    L_NO,   C_NEVER,  PC_OPEN,   1'b0, 1'b0);
            PC_BRK_Q2:   u = mk(E_QUOTE,  C_BRK,    L_NO,   C_NEVER,  PC_OPEN,   1'b0, 1'b0);
            PC_RAW:      u = mk(E_RAW,    C_ALWAYS, L_YES,  C_NEVER,  PC_OPEN,   1'b0, 1'b1);
            default:     u = mk(E_NONE,   C_NEVER,  L_NO,   C_NEVER,  PC_OPEN,   1'b0, 1'b1);
        endcase
        return u;
    endfunction

    function automatic logic eval_cond(input t_cond c, input t_flags f);
        logic r;
        case (c)
            C_NEVER:  r = 1'b0;
            C_ALWAYS: r = 1'b1;
            C_OPEN:   r = f.need_open;
            C_SINGLE: r = f.single;
            C_NO_HEX: r = f.no_hex;
            C_CLOSE:  r = f.close;
            C_HI:     r = f.hi;
            C_ESC:    r = f.esc;
            C_NO_ESC: r = !f.esc;
            C_BRK:    r = f.brk;
            C_MORE:   r = f.more;
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b >= CONT_LO) && (b < LEAD2_LO);
    endfunction

    function automatic logic is_hex_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] n;
        if (b < LEAD2_LO) begin
            n = 3'd1;
        end else if (b < LEAD3_LO) begin
            n = 3'd2;
        end else if (b < LEAD4_LO) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    function automatic logic chunk_ok(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input logic [7:0] b3,
                                      input logic [2:0] n);
        logic ok;
        case (n)
            3'd1: ok = b0 < CONT_LO;
            3'd2: ok = (b0 > OVER2_MAX) && is_cont(b1);
            3'd3: ok = (b0 != LEAD3_LO || b1 >= SURR_LO) && (b0 != SURR_LEAD || b1 < SURR_LO)
                       && is_cont(b1) && is_cont(b2);
            3'd4: ok = (b0 <= LEAD_MAX) && (b0 != LEAD4_LO || b1 >= PLANE_LO)
                       && (b0 != LEAD_MAX || b1 < PLANE_LO)
                       && is_cont(b1) && is_cont(b2) && is_cont(b3);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h41 + {4'h0, v} - 8'd10);
    endfunction

    function automatic logic [7:0] esc_letter(input logic [7:0] c);
        logic [7:0] e;
        case (c)
            8'h22:   e = 8'h22;
            8'h5C:   e = 8'h5C;
            8'h07:   e = 8'h61;
            8'h08:   e = 8'h62;
            8'h0C:   e = 8'h66;
            8'h0A:   e = 8'h6E;
            8'h0D:   e = 8'h72;
            8'h09:   e = 8'h74;
            8'h0B:   e = 8'h76;
            default: e = 8'h00;
        endcase
        return e;
    endfunction

endpackage

// ===== src/utf8_c_string_escaper.sv =====
// Top level of the UTF-8 checking C string escaper with its microcoded sequencer.
// The block takes one item at a time and sends its characters one by one through an output
// register; a small program in a read-only table steps through the quotes and escapes. After
// the accept cycle, an item that only holds a byte of a longer character, a backslash-letter
// escape, a raw character or a chunk of bytes sent as hex escapes runs its own path through
// that program, one step per cycle of the sequencer; a stalled output holds the sequencer
// on the step that wants to send.
module utf8_c_string_escaper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_opcode,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_out_last
);

    logic [7:0] r_buf [4];
    logic [1:0] r_fill;
    logic [2:0] r_need;
    logic       r_after_hex;
    logic       r_open;

    logic       r_busy;
    logic [u8esc_pkg::PC_W-1:0] r_pc;
    logic [1:0] r_idx;
    logic       r_need_open;
    logic       r_close;
    logic       r_single;
    logic [2:0] r_cnt;
    logic       r_brk;

    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;

    logic [u8esc_pkg::PC_W-1:0] n_pc;
    logic [1:0] n_idx;

    logic       accept;
    logic [7:0] w [4];
    logic [2:0] len;
    logic [2:0] fill_p1;
    logic       complete;
    logic       single_ok;

    u8esc_pkg::t_uop   uop;
    u8esc_pkg::t_flags flags;
    logic [7:0] cur;
    logic [7:0] letter;
    logic       emit_go;
    logic       out_free;
    logic       step;
    logic       jump;
    logic [7:0] emit_char;
    logic       emit_last;

    assign accept   = i_valid && o_ready;
    assign o_ready  = !r_busy;
    assign o_valid  = r_out_valid;
    assign o_out_char = r_out_char;
    assign o_out_last = r_out_last;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w[i] = (r_fill == 2'(i)) ? i_data_byte : r_buf[i];
        end
    end

    assign len       = (r_fill == 2'd0) ? u8esc_pkg::lead_len(i_data_byte) : r_need;
    assign fill_p1   = {1'b0, r_fill} + 3'd1;
    assign complete  = fill_p1 >= len;
    assign single_ok = (r_fill == 2'd0) && u8esc_pkg::chunk_ok(w[0], w[1], w[2], w[3], fill_p1);

    always_ff @(posedge i_clk) begin
        if (accept && !i_opcode) begin
            r_buf[r_fill] <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= 2'd0;
            r_need      <= 3'd1;
            r_after_hex <= 1'b0;
            r_open      <= 1'b0;
            r_need_open <= 1'b0;
            r_close     <= 1'b0;
            r_single    <= 1'b0;
            r_cnt       <= 3'd0;
            r_brk       <= 1'b0;
        end else if (accept) begin
            r_need_open <= !r_open;
            r_close     <= i_opcode;
            if (i_opcode) begin
                r_cnt       <= {1'b0, r_fill};
                r_single    <= 1'b0;
                r_brk       <= 1'b0;
                r_fill      <= 2'd0;
                r_need      <= 3'd1;
                r_after_hex <= 1'b0;
                r_open      <= 1'b0;
            end else begin
                r_open <= 1'b1;
                r_brk  <= r_after_hex && u8esc_pkg::is_hex_digit(i_data_byte);
                if (complete) begin
                    r_single    <= single_ok;
                    r_cnt       <= single_ok ? 3'd0 : fill_p1;
                    r_fill      <= 2'd0;
                    r_need      <= 3'd1;
                    r_after_hex <= !single_ok;
                end else begin
                    r_single <= 1'b0;
                    r_cnt    <= 3'd0;
                    r_fill   <= r_fill + 2'd1;
                    r_need   <= len;
                end
            end
        end
    end

    assign uop    = u8esc_pkg::ucode(r_pc);
    assign cur    = r_buf[r_idx];
    assign letter = u8esc_pkg::esc_letter(cur);

    always_comb begin
        flags.need_open = r_need_open;
        flags.single    = r_single;
        flags.no_hex    = r_cnt == 3'd0;
        flags.close     = r_close;
        flags.hi        = cur[7:4] != 4'h0;
        flags.esc       = letter != 8'h00;
        flags.brk       = r_brk;
        flags.more      = ({1'b0, r_idx} + 3'd1) < r_cnt;
    end

    assign emit_go  = (uop.emit != u8esc_pkg::E_NONE)
                      && u8esc_pkg::eval_cond(uop.emit_cond, flags);
    assign out_free = !r_out_valid || i_ready;
    assign step     = r_busy && (!emit_go || out_free);
    assign jump     = u8esc_pkg::eval_cond(uop.jump_cond, flags);

    always_comb begin
        case (uop.emit)
            u8esc_pkg::E_QUOTE:  emit_char = u8esc_pkg::CH_QUOTE;
            u8esc_pkg::E_BSL:    emit_char = u8esc_pkg::CH_BSL;
            u8esc_pkg::E_X:      emit_char = u8esc_pkg::CH_X;
            u8esc_pkg::E_HI:     emit_char = u8esc_pkg::hex_char(cur[7:4]);
            u8esc_pkg::E_LO:     emit_char = u8esc_pkg::hex_char(cur[3:0]);
            u8esc_pkg::E_RAW:    emit_char = cur;
            u8esc_pkg::E_LETTER: emit_char = letter;
            u8esc_pkg::E_SPACE:  emit_char = u8esc_pkg::CH_SPACE;
            default:             emit_char = 8'h00;
        endcase
    end

    always_comb begin
        case (uop.last)
            u8esc_pkg::L_NO:   emit_last = 1'b0;
            u8esc_pkg::L_YES:  emit_last = 1'b1;
            u8esc_pkg::L_OPEN: emit_last = !r_close && (r_cnt == 3'd0) && !r_single;
            u8esc_pkg::L_BYTE: emit_last = !flags.more && !r_close;
            default:           emit_last = 1'b0;
        endcase
    end

    assign n_pc  = jump ? uop.target : r_pc + 4'd1;
    assign n_idx = uop.inc_idx ? r_idx + 2'd1 : r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= u8esc_pkg::PC_OPEN;
            r_idx  <= 2'd0;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_pc   <= u8esc_pkg::PC_OPEN;
            r_idx  <= 2'd0;
        end else if (step) begin
            r_busy <= !uop.done;
            r_pc   <= n_pc;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && emit_go) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit_go) begin
            r_out_char <= emit_char;
            r_out_last <= emit_last;
        end
    end

    a_fill_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == 2'd0) == (r_need == 3'd1))
        else $error("Chunk fill and chunk length disagree.");

    a_fill_below_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_fill} < r_need)
        else $error("A held chunk is as long as its lead allows.");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_pc <= u8esc_pkg::PC_RAW)
        else $error("The sequencer left its program.");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && uop.done) |=> !r_busy)
        else $error("The sequencer did not finish the item on its last step.");

endmodule

// ===== verif/utf8_c_string_escaper_test.sv =====
// Self-checking testbench for the UTF-8 checking C string escaper, with a built-in predictor.
`timescale 1ns / 1ps

module utf8_c_string_escaper_test;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam int ITEMS_PER_PHASE = 46;
    localparam int NUM_PHASES      = 5;
    localparam int MAX_SRC_GAP     = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_out_char;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } t_byte_item;

    typedef struct {
        logic       op;
        logic [7:0] data;
        string      typed;
    } t_dir_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       i_opcode    = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_ready     = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_char;
    logic       o_out_last;

    utf8_c_string_escaper u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_char  (o_out_char),
        .o_out_last  (o_out_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor state.
    logic [2:0][7:0] held_bytes  = '0;
    logic [1:0]      held_count  = 2'd0;
    logic [2:0]      chunk_len   = 3'd1;
    logic            hex_pending = 1'b0;
    logic            quote_open  = 1'b0;

    logic [7:0] step_chars[$];
    t_out_char  expected_chars[$];
    t_byte_item stim_q[$];
    t_dir_row   dir_rows[$];

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    bit          hold_off_req   = 1'b0;
    int          errors         = 0;
    int          idle_cycles    = 0;

    function automatic logic cont_byte(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    function automatic logic hex_digit_char(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46)
               || (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] n;
        if (b < 8'hC0) begin
            n = 3'd1;
        end else if (b < 8'hE0) begin
            n = 3'd2;
        end else if (b < 8'hF0) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    function automatic logic seq_ok(input logic [3:0][7:0] s, input int n);
        logic ok;
        int   i;
        case (n)
            1: ok = s[0] < 8'h80;
            2: ok = s[0] > 8'hC1;
            3: ok = !(s[0] == 8'hE0 && s[1] < 8'hA0) && !(s[0] == 8'hED && s[1] >= 8'hA0);
            default: ok = s[0] <= 8'hF4 && !(s[0] == 8'hF0 && s[1] < 8'h90)
                          && !(s[0] == 8'hF4 && s[1] >= 8'h90);
        endcase
        for (i = 1; i < n; i++) begin
            if (!cont_byte(s[i])) ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h37 + 8'(v);
    endfunction

    function automatic logic [7:0] escape_for(input logic [7:0] c);
        logic [7:0] e;
        case (c)
            u8esc_pkg::CH_QUOTE: e = u8esc_pkg::CH_QUOTE;
            u8esc_pkg::CH_BSL:   e = u8esc_pkg::CH_BSL;
            8'h07:    e = "a";
            8'h08:    e = "b";
            8'h0C:    e = "f";
            8'h0A:    e = "n";
            8'h0D:    e = "r";
            8'h09:    e = "t";
            8'h0B:    e = "v";
            default:  e = 8'h00;
        endcase
        return e;
    endfunction

    function automatic void emit_seq(input logic [3:0][7:0] s, input int n, input logic ok);
        logic [7:0] letter;
        int         i;
        if (ok && n == 1) begin
            letter = escape_for(s[0]);
            if (letter != 8'h00) begin
                step_chars.push_back(u8esc_pkg::CH_BSL);
                step_chars.push_back(letter);
            end else begin
                if (hex_pending && hex_digit_char(s[0])) begin
                    step_chars.push_back(u8esc_pkg::CH_QUOTE);
                    step_chars.push_back(u8esc_pkg::CH_SPACE);
                    step_chars.push_back(u8esc_pkg::CH_QUOTE);
                end
                step_chars.push_back(s[0]);
            end
            hex_pending = 1'b0;
        end else begin
            for (i = 0; i < n; i++) begin
                step_chars.push_back(u8esc_pkg::CH_BSL);
                step_chars.push_back(u8esc_pkg::CH_X);
                if (s[i] >= 8'h10) step_chars.push_back(nibble_char(s[i][7:4]));
                step_chars.push_back(nibble_char(s[i][3:0]));
            end
            hex_pending = 1'b1;
        end
    endfunction

    function automatic void predict_literal(input logic op, input logic [7:0] b);
        logic [3:0][7:0] s;
        int              i;
        s = '0;
        step_chars.delete();
        if (!quote_open) begin
            step_chars.push_back(u8esc_pkg::CH_QUOTE);
            quote_open = 1'b1;
        end
        if (op == OP_END) begin
            for (i = 0; i < held_count; i++) s[i] = held_bytes[i];
            if (held_count > 0) emit_seq(s, int'(held_count), 1'b0);
            step_chars.push_back(u8esc_pkg::CH_QUOTE);
            held_count  = 2'd0;
            chunk_len   = 3'd1;
            hex_pending = 1'b0;
            quote_open  = 1'b0;
        end else if (held_count == 0) begin
            chunk_len = seq_len(b);
            if (chunk_len == 3'd1) begin
                s[0] = b;
                emit_seq(s, 1, seq_ok(s, 1));
            end else begin
                held_bytes[0] = b;
                held_count    = 2'd1;
            end
        end else if (held_count + 1 >= chunk_len || held_count == 2'd3) begin
            for (i = 0; i < held_count; i++) s[i] = held_bytes[i];
            s[held_count] = b;
            emit_seq(s, held_count + 1, seq_ok(s, held_count + 1));
            held_count = 2'd0;
            chunk_len  = 3'd1;
        end else begin
            held_bytes[held_count] = b;
            held_count             = held_count + 2'd1;
        end
    endfunction

    function automatic void push_data(input logic [7:0] b);
        stim_q.push_back('{op: OP_DATA, data: b});
    endfunction

    function automatic logic [7:0] any_cont();
        return 8'($urandom_range(8'hBF, 8'h80));
    endfunction

    function automatic logic [7:0] pick_ascii();
        logic [7:0] b;
        case ($urandom_range(3))
            0: b = 8'($urandom_range(8'h7F, 8'h00));
            1: begin
                case ($urandom_range(2))
                    0:       b = 8'($urandom_range(8'h39, 8'h30));
                    1:       b = 8'($urandom_range(8'h46, 8'h41));
                    default: b = 8'($urandom_range(8'h66, 8'h61));
                endcase
            end
            2: begin
                case ($urandom_range(8))
                    0:       b = u8esc_pkg::CH_QUOTE;
                    1:       b = u8esc_pkg::CH_BSL;
                    2:       b = 8'h07;
                    3:       b = 8'h08;
                    4:       b = 8'h0C;
                    5:       b = 8'h0A;
                    6:       b = 8'h0D;
                    7:       b = 8'h09;
                    default: b = 8'h0B;
                endcase
            end
            default: b = 8'($urandom_range(8'h7E, 8'h20));
        endcase
        return b;
    endfunction

    function automatic void push_good_seq();
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        case ($urandom_range(2))
            0: begin
                push_data(8'($urandom_range(8'hDF, 8'hC2)));
                push_data(any_cont());
            end
            1: begin
                lead = 8'($urandom_range(8'hEF, 8'hE0));
                if ($urandom_range(3) == 0) lead = $urandom_range(1) ? 8'hE0 : 8'hED;
                if (lead == 8'hE0) lo = 8'hA0;
                if (lead == 8'hED) hi = 8'h9F;
                push_data(lead);
                push_data(8'($urandom_range(hi, lo)));
                push_data(any_cont());
            end
            default: begin
                lead = 8'($urandom_range(8'hF4, 8'hF0));
                if (lead == 8'hF0) lo = 8'h90;
                if (lead == 8'hF4) hi = 8'h8F;
                push_data(lead);
                push_data(8'($urandom_range(hi, lo)));
                push_data(any_cont());
                push_data(any_cont());
            end
        endcase
    endfunction

    function automatic void push_bad_seq();
        logic [7:0] lead;
        int         n;
        int         bad_pos;
        int         j;
        case ($urandom_range(6))
            0: push_data(any_cont());
            1: begin
                push_data(8'($urandom_range(8'hC1, 8'hC0)));
                push_data(any_cont());
            end
            2: begin
                push_data(8'hE0);
                push_data(8'($urandom_range(8'h9F, 8'h80)));
                push_data(any_cont());
            end
            3: begin
                push_data(8'hED);
                push_data(8'($urandom_range(8'hBF, 8'hA0)));
                push_data(any_cont());
            end
            4: begin
                push_data(8'hF0);
                push_data(8'($urandom_range(8'h8F, 8'h80)));
                push_data(any_cont());
                push_data(any_cont());
            end
            5: begin
                lead = 8'($urandom_range(8'hFF, 8'hF4));
                push_data(lead);
                push_data(lead == 8'hF4 ? 8'($urandom_range(8'hBF, 8'h90)) : any_cont());
                push_data(any_cont());
                push_data(any_cont());
            end
            default: begin
                lead    = 8'($urandom_range(8'hF4, 8'hC2));
                n       = seq_len(lead);
                bad_pos = $urandom_range(n - 1, 1);
                push_data(lead);
                for (j = 1; j < n; j++) begin
                    if (j != bad_pos) begin
                        push_data(any_cont());
                    end else if ($urandom_range(1)) begin
                        push_data(8'($urandom_range(8'h7F, 8'h00)));
                    end else begin
                        push_data(8'($urandom_range(8'hFF, 8'hC0)));
                    end
                end
            end
        endcase
    endfunction

    function automatic void build_string();
        int         nchars;
        int         k;
        int         kind;
        logic [7:0] lead;
        nchars = $urandom_range(10);
        for (k = 0; k < nchars; k++) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                push_data(pick_ascii());
            end else if (kind < 65) begin
                push_good_seq();
            end else if (kind < 90) begin
                push_bad_seq();
            end else begin
                push_data(8'($urandom_range(255)));
            end
        end
        if ($urandom_range(99) < 15) begin
            lead = 8'($urandom_range(8'hFF, 8'hC0));
            push_data(lead);
            for (k = $urandom_range(seq_len(lead) - 2); k > 0; k--) push_data(any_cont());
        end
        stim_q.push_back('{op: OP_END, data: 8'($urandom_range(255))});
    endfunction

    function automatic void add_row(input logic op, input logic [7:0] data, input string typed);
        dir_rows.push_back('{op, data, typed});
    endfunction

    task automatic send_item(input logic op, input logic [7:0] data, input string typed);
        int gap;
        int k;
        gap = 0;
        while (gap < MAX_SRC_GAP && $urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_data_byte <= data;
        do @(posedge i_clk); while (!o_ready);
        predict_literal(op, data);
        if (typed.len() > 0) begin
            step_chars.delete();
            for (k = 0; k < typed.len(); k++) step_chars.push_back(typed[k]);
        end
        for (k = 0; k < step_chars.size(); k++) begin
            expected_chars.push_back('{ch: step_chars[k], last: (k == step_chars.size() - 1)});
        end
    endtask

    initial begin : sink_ctl
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            i_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_char want;
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected char: expected none, actual %h last %b",
                         $time, o_out_char, o_out_last);
                errors++;
            end else begin
                want = expected_chars.pop_front();
                if (o_out_char !== want.ch) begin
                    $display("%0t: out_char mismatch: expected %h, actual %h",
                             $time, want.ch, o_out_char);
                    errors++;
                end
                if (o_out_last !== want.last) begin
                    $display("%0t: out_last mismatch: expected %b, actual %b",
                             $time, want.last, o_out_last);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int         ph;
        int         phase_items;
        t_byte_item it;
        t_dir_row   row;

        add_row(OP_END,  8'hFF, "\"\"");
        add_row(OP_DATA, 8'h00, "");
        add_row(OP_DATA, 8'h07, "\\a");
        add_row(OP_DATA, 8'h08, "\\b");
        add_row(OP_DATA, 8'h0C, "\\f");
        add_row(OP_DATA, 8'h0A, "\\n");
        add_row(OP_DATA, 8'h0D, "\\r");
        add_row(OP_DATA, 8'h09, "\\t");
        add_row(OP_DATA, 8'h0B, "\\v");
        add_row(OP_DATA, 8'h22, "\\\"");
        add_row(OP_DATA, 8'h5C, "\\\\");
        add_row(OP_DATA, 8'h80, "\\x80");
        add_row(OP_DATA, 8'h41, "\" \"A");
        add_row(OP_DATA, 8'hFF, "");
        add_row(OP_DATA, 8'h80, "");
        add_row(OP_DATA, 8'h80, "");
        add_row(OP_DATA, 8'hBF, "\\xFF\\x80\\x80\\xBF");
        add_row(OP_DATA, 8'hC2, "");
        add_row(OP_DATA, 8'h05, "\\xC2\\x5");
        add_row(OP_DATA, 8'h30, "\" \"0");
        add_row(OP_DATA, 8'h7F, "");
        add_row(OP_DATA, 8'hC0, "");
        add_row(OP_DATA, 8'h80, "\\xC0\\x80");
        add_row(OP_DATA, 8'hF4, "");
        add_row(OP_END,  8'h00, "\\xF4\"");

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (dir_rows.size() > 0) begin
            row = dir_rows.pop_front();
            send_item(row.op, row.data, row.typed);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 75;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 75;
                end
                3: begin
                    src_idle_pct   = 36;
                    sink_stall_pct = 36;
                end
                default: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                    hold_off_req   = 1'b1;
                end
            endcase
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                build_string();
                while (stim_q.size() > 0) begin
                    it = stim_q.pop_front();
                    send_item(it.op, it.data, "");
                    phase_items++;
                end
            end
        end

        i_valid <= 1'b0;
        sink_stall_pct = 0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/u8esc_pkg.sv
src/utf8_c_string_escaper.sv
verif/utf8_c_string_escaper_test.sv
